// ----- src/pcrf_pkg.sv -----
`default_nettype none

package pcrf_pkg;

	// field widths
	localparam int unsigned OffsetW = 3;
	localparam int unsigned DataW   = 16;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned RegionW = 3;
	localparam int unsigned KeyW    = 4;

	// register map of the configuration port
	localparam int unsigned PaddrW    = 3;
	localparam int unsigned PdataW    = 32;
	localparam logic [0:0]  RegRegion = 1'b0;

	// write commands
	localparam logic [7:0] CmdLatch0  = 8'h00;
	localparam logic [7:0] CmdLatch1  = 8'h01;
	localparam logic [7:0] CmdLatch2  = 8'h02;
	localparam logic [7:0] CmdHoldRd  = 8'h03;
	localparam logic [7:0] CmdShift   = 8'h40;
	localparam logic [7:0] CmdKey     = 8'h48;
	localparam logic [4:0] CmdHoldAdv = 5'b10000;
	localparam logic [7:0] CmdHoldClr = 8'ha0;

	// region codes
	localparam logic [2:0] Region0 = 3'd0;
	localparam logic [2:0] Region1 = 3'd1;
	localparam logic [2:0] Region2 = 3'd2;
	localparam logic [2:0] Region3 = 3'd3;
	localparam logic [2:0] Region4 = 3'd4;

	// hold and key constants
	localparam logic [15:0] HoldXor  = 16'h2bad;
	localparam logic [15:0] KeyMask0 = 16'h0090;
	localparam logic [15:0] KeyMask1 = 16'h0006;
	localparam logic [15:0] KeyMask2 = 16'h9000;
	localparam logic [15:0] KeyMask3 = 16'h0a00;
	localparam logic [7:0]  Latch0Mask = 8'hf7;
	localparam logic [7:0]  Latch2Mask = 8'h7f;

	// one bus word
	typedef struct packed {
		logic               action;
		logic [OffsetW-1:0] offset;
		logic [DataW-1:0]   data;
	} item_t;

	// fixed id bytes by command, zero where none
	function automatic logic [ByteW-1:0] id_byte(input logic [7:0] cmd);
		logic [ByteW-1:0] b;
		unique case (cmd)
			8'h20: b = 8'h49;
			8'h21: b = 8'h47;
			8'h22: b = 8'h53;
			8'h24: b = 8'h41;
			8'h25: b = 8'h41;
			8'h26: b = 8'h7f;
			8'h27: b = 8'h41;
			8'h28: b = 8'h41;
			8'h2a: b = 8'h3e;
			8'h2b: b = 8'h41;
			8'h2c: b = 8'h49;
			8'h2d: b = 8'hf9;
			8'h2e: b = 8'h0a;
			8'h30: b = 8'h26;
			8'h31: b = 8'h49;
			8'h32: b = 8'h49;
			8'h33: b = 8'h49;
			8'h34: b = 8'h32;
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- src/pcrf_cfg.sv -----
`default_nettype none

module pcrf_cfg
	import pcrf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PaddrW-1:0]  paddr,
	input  wire logic [PdataW-1:0]  pwdata,
	output logic      [PdataW-1:0]  prdata,
	output logic                    pready,
	output logic      [RegionW-1:0] region
);

	logic [RegionW-1:0] region_q;
	logic               hit_region;

	// address decode, one register at byte address zero
	assign hit_region = (paddr[PaddrW-1:2] == RegRegion);
	assign pready     = 1'b1;

	// region register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= '0;
		end else if (psel && penable && pwrite && pready && hit_region) begin
			region_q <= pwdata[RegionW-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (hit_region) begin
			prdata[RegionW-1:0] = region_q;
		end
	end

	assign region = region_q;

endmodule

`default_nettype wire

// ----- src/pcrf_core.sv -----
`default_nettype none

module pcrf_core
	import pcrf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire item_t              item,
	input  wire logic [RegionW-1:0] region,
	output logic      [ByteW-1:0]   rdata
);

	logic [7:0]       command_q;
	logic [ByteW-1:0] latch_q [3];
	logic [KeyW-1:0]  key_q;
	logic [15:0]      shift_q;
	logic [15:0]      hold_q;

	logic             wr_cmd;
	logic             wr_op;
	logic [KeyW-1:0]  key_next;
	logic [15:0]      hold_adv;
	logic [15:0]      taps;
	logic [15:0]      old;

	assign wr_cmd = fire && item.action && (item.offset == '0);
	assign wr_op  = fire && item.action && (item.offset != '0);
	assign old    = hold_q;

	// key from masked tests of the shift word
	assign key_next = {(shift_q & KeyMask3) == '0, (shift_q & KeyMask2) == '0,
		(shift_q & KeyMask1) == '0, (shift_q & KeyMask0) == '0};

	// region dependent taps of the hold advance
	always_comb begin
		taps = '0;
		unique case (region)
			Region0, Region1: begin
				taps[0]  = old[10] ^ old[8];
				taps[1]  = key_q[0];
				taps[6]  = key_q[1];
				taps[14] = key_q[3];
			end
			Region2: begin
				taps[0]  = old[10] ^ old[8];
				taps[4]  = key_q[0];
				taps[6]  = key_q[1];
				taps[12] = key_q[3];
			end
			Region3: begin
				taps[0]  = old[7] ^ old[6];
				taps[4]  = key_q[0];
				taps[6]  = key_q[1];
				taps[12] = key_q[3];
			end
			Region4: begin
				taps[0]  = old[7] ^ old[6];
				taps[3]  = key_q[0];
				taps[8]  = key_q[1];
				taps[14] = key_q[3];
			end
			default: begin
				taps = '0;
			end
		endcase
	end

	// rotate left, fixed xor, data bit, old bit 5, key bit 2 and tap bits
	always_comb begin
		hold_adv     = {old[14:0], old[15]} ^ HoldXor ^ taps;
		hold_adv[0]  = hold_adv[0] ^ item.data[{1'b0, command_q[2:0]}] ^ old[5];
		hold_adv[10] = hold_adv[10] ^ key_q[2];
	end

	// state update on each accepted write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q  <= '0;
			latch_q[0] <= '0;
			latch_q[1] <= '0;
			latch_q[2] <= '0;
			key_q      <= '0;
			shift_q    <= '0;
			hold_q     <= '0;
		end else if (wr_cmd) begin
			command_q <= item.data[7:0];
		end else if (wr_op) begin
			priority if (command_q == CmdLatch0) begin
				latch_q[0] <= {item.data[6:0], 1'b0};
			end else if (command_q == CmdLatch1) begin
				latch_q[1] <= {item.data[6:0], 1'b0};
			end else if (command_q == CmdLatch2) begin
				latch_q[2] <= {item.data[6:0], 1'b0};
			end else if (command_q == CmdShift) begin
				shift_q <= {shift_q[7:0], 8'h00} | item.data;
			end else if (command_q == CmdKey) begin
				key_q <= key_next;
			end else if (command_q[7:3] == CmdHoldAdv) begin
				hold_q <= hold_adv;
			end else if (command_q == CmdHoldClr) begin
				hold_q <= '0;
			end else begin
				hold_q <= hold_q;
			end
		end
	end

	// read byte by command, zero for writes
	always_comb begin
		rdata = '0;
		if (!item.action) begin
			unique case (command_q)
				CmdLatch0: rdata = (latch_q[0] & Latch0Mask) | {4'b0, region[0], 3'b0};
				CmdLatch1: rdata = latch_q[1];
				CmdLatch2: rdata = (latch_q[2] & Latch2Mask) | {region[1], 7'b0};
				CmdHoldRd: rdata = {hold_q[5], hold_q[2], hold_q[9], hold_q[7],
					hold_q[10], hold_q[13], hold_q[12], hold_q[15]};
				default:   rdata = id_byte(command_q);
			endcase
		end
	end

	// command select takes the low byte
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_cmd |=> (command_q == $past(item.data[7:0])))
		else $error("command select lost");

	// shift in places the new word in the low byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_op && command_q == CmdShift) |=> (shift_q[7:0] == $past(item.data[7:0])))
		else $error("shift word not updated");

	// clear command empties hold
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_op && command_q == CmdHoldClr) |=> (hold_q == '0))
		else $error("hold not cleared");

endmodule

`default_nettype wire

// ----- src/protection_chip_register_file.sv -----
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   action, offset, data
// out      from block out_valid / out_stall read_data
// cfg      to block   psel / penable        pwrite, paddr, pwdata, prdata, pready
//
// one word per cycle sustained while out is not stalled; a word's result reaches read_data
// through the input register, then the result register, state changes in that pass
// reset clears the valid flags, command, latches, key, shift and hold words and region
// a stall at out holds the result register; in stalls only once the input register
// is also full and cannot move on
`default_nettype none

module protection_chip_register_file
	import pcrf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              action,
	input  wire logic [OffsetW-1:0] offset,
	input  wire logic [DataW-1:0]  data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [ByteW-1:0]  read_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [PaddrW-1:0] paddr,
	input  wire logic [PdataW-1:0] pwdata,
	output logic      [PdataW-1:0] prdata,
	output logic                   pready
);

	logic               valid_s1;
	item_t              item_s1;
	logic               out_valid_q;
	logic [ByteW-1:0]   read_data_q;
	logic               advance;
	logic               accept;
	logic [ByteW-1:0]   rdata;
	logic [RegionW-1:0] region;

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{action: action, offset: offset, data: data};
		end
	end

	// configuration registers
	pcrf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.region  (region)
	);

	// state and read logic
	pcrf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.region (region),
		.rdata  (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rdata;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule

`default_nettype wire
